// ===== rtl/aotq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aotq_pkg: shared types and constants
// Table size, op and status codes, and the structs that run between the
// controller and the row of table cells.
// ----------------------------------------------------------------------------
package aotq_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDXW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW     = $clog2(ENTRIES + 1);
  localparam int MAX_HITS = 64;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_MOVE   = 3'd2,
    OP_RESIZE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_QUERY  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FLUSH
  } fsm_e;

  // Candidate handed from cell to cell during a scan pass.
  typedef struct packed {
    logic            vld;
    logic [15:0]     sort_val;
    logic [15:0]     key;
    logic [IDXW-1:0] idx;
  } cand_t;

  // Per-cell command bits.
  typedef struct packed {
    logic add;
    logic del;
    logic move;
    logic resize;
    logic clear;
    logic qstart;
    logic pick;
  } cell_cmd_t;

endpackage

// ===== rtl/aotq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aotq_cell: one table slot
// Holds one box, its query flags and one stage of the candidate chain.
// ----------------------------------------------------------------------------
module aotq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [aotq_pkg::IDXW-1:0] cell_idx_i,
  input  aotq_pkg::cell_cmd_t  cmd_i,
  input  logic [15:0]          new_key_i,
  input  logic [15:0]          pos_x_i,
  input  logic [15:0]          pos_y_i,
  input  logic [15:0]          size_w_i,
  input  logic [15:0]          size_h_i,
  input  logic [16:0]          q_xb_i,
  input  logic [16:0]          q_yb_i,
  input  logic                 sort_by_y_i,
  input  aotq_pkg::cand_t      cand_i,
  output aotq_pkg::cand_t      cand_o,
  output logic                 valid_o,
  output logic [15:0]          key_o
);
  import aotq_pkg::*;

  logic        valid_q, hit_q, done_q;
  logic [15:0] key_q, left_q, top_q, width_q, height_q;
  cand_t       cand_q, mine, cand_d;
  logic        overlap;

  assign overlap = valid_q
      && (({1'b0, left_q} + {1'b0, width_q}) > {1'b0, pos_x_i})
      && ({1'b0, left_q} < q_xb_i)
      && (({1'b0, top_q} + {1'b0, height_q}) > {1'b0, pos_y_i})
      && ({1'b0, top_q} < q_yb_i);

  always_comb begin
    mine.vld      = hit_q && !done_q;
    mine.sort_val = sort_by_y_i ? top_q : left_q;
    mine.key      = key_q;
    mine.idx      = cell_idx_i;
    // The incoming candidate comes from a lower slot, so it wins full ties.
    if (!cand_i.vld) begin
      cand_d = mine;
    end else if (mine.vld && ((mine.sort_val < cand_i.sort_val) ||
               ((mine.sort_val == cand_i.sort_val) && (mine.key < cand_i.key)))) begin
      cand_d = mine;
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
      cand_q  <= '0;
    end else begin
      cand_q <= cand_d;
      if (cmd_i.clear || cmd_i.del) begin
        valid_q <= 1'b0;
      end else if (cmd_i.add) begin
        valid_q <= 1'b1;
      end
      if (cmd_i.qstart) begin
        hit_q  <= overlap;
        done_q <= 1'b0;
      end else if (cmd_i.pick) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      key_q <= new_key_i;
    end
    if (cmd_i.add || cmd_i.move) begin
      left_q <= pos_x_i;
      top_q  <= pos_y_i;
    end
    if (cmd_i.add || cmd_i.resize) begin
      width_q  <= size_w_i;
      height_q <= size_h_i;
    end
  end

  assign cand_o  = cand_q;
  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

// ===== rtl/aabb_table_overlap_query_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_table_overlap_query_unit: box table with sorted overlap query
// Keeps a table of boxes in a row of cells and reports, in sorted order,
// the keys of the boxes that overlap a query rectangle.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Fields
//  request   start_i / busy_o      op_i box_key_i pos_x_i pos_y_i size_w_i
//                                  size_h_i hit_limit_i
//  result    res_valid_o (strobe)  status_o out_key_o hit_o hit_count_o last_o
//  config    cfg_we_i              cfg_wdata_i (sort_by_y)
//
// Add, delete, move, resize, clear and unknown ops finish in the accept cycle:
// the result strobes in the cycle after and busy_o never rises.
// A query with a nonzero limit runs one full pass of the minimum search down
// the cell chain, ENTRIES stages long, for every hit; one more pass proves that
// no hit is left, unless the hit limit has already ended the query.
// Reset clears the table valid bits, the key counter and sort_by_y.
// Results cannot be stalled; each strobe lasts exactly one cycle.
//
module aabb_table_overlap_query_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] box_key_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] size_w_i,
  input  logic [15:0] size_h_i,
  input  logic [6:0]  hit_limit_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        res_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_key_o,
  output logic        hit_o,
  output logic [6:0]  hit_count_o,
  output logic        last_o
);
  import aotq_pkg::*;

  fsm_e              state_q, state_d;
  logic              sort_by_y_q;
  logic [15:0]       next_key_q, next_key_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [6:0]        n_q, n_d, lim_q, lim_d;
  logic              pend_v_q, pend_v_d;
  logic [15:0]       pend_key_q, pend_key_d;
  logic [16:0]       qxb_q, qyb_q;
  logic [15:0]       qx_q, qy_q;

  logic              res_valid_q, res_valid_d;
  logic [1:0]        status_q, status_d;
  logic [15:0]       out_key_q, out_key_d;
  logic              hit_q, hit_d;
  logic [6:0]        hit_count_q, hit_count_d;
  logic              last_q, last_d;

  cand_t             chain [ENTRIES+1];
  cell_cmd_t         cmd [ENTRIES];
  logic [ENTRIES-1:0] valid_vec, match_vec, free_1h, match_1h, pick_vec;
  logic [15:0]       key_vec [ENTRIES];
  logic [16:0]       cell_xb, cell_yb;
  logic [15:0]       cell_x, cell_y;
  logic              is_idle;

  assign chain[0] = '0;
  assign is_idle  = (state_q == FSM_IDLE);
  // Query flags are set from the live inputs in the accept cycle; outside idle the cells see the registered rectangle.
  assign cell_x   = is_idle ? pos_x_i : qx_q;
  assign cell_y   = is_idle ? pos_y_i : qy_q;
  assign cell_xb  = {1'b0, pos_x_i} + {1'b0, size_w_i};
  assign cell_yb  = {1'b0, pos_y_i} + {1'b0, size_h_i};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    aotq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDXW'(g)),
      .cmd_i       (cmd[g]),
      .new_key_i   (next_key_q),
      .pos_x_i     (cell_x),
      .pos_y_i     (cell_y),
      .size_w_i    (size_w_i),
      .size_h_i    (size_h_i),
      .q_xb_i      (is_idle ? cell_xb : qxb_q),
      .q_yb_i      (is_idle ? cell_yb : qyb_q),
      .sort_by_y_i (sort_by_y_q),
      .cand_i      (chain[g]),
      .cand_o      (chain[g+1]),
      .valid_o     (valid_vec[g]),
      .key_o       (key_vec[g])
    );
    assign match_vec[g] = valid_vec[g] && (key_vec[g] == box_key_i);
    assign pick_vec[g]  = chain[ENTRIES].vld && (chain[ENTRIES].idx == IDXW'(g));
  end

  // Lowest free slot and lowest matching slot, one-hot.
  assign free_1h  = ~valid_vec & (valid_vec + ENTRIES'(1));
  assign match_1h = match_vec & (~match_vec + ENTRIES'(1));

  always_comb begin
    logic accept;
    logic do_add, do_del, do_move, do_resize, do_clear, do_qstart, do_pick;
    accept      = start_i && is_idle;
    state_d     = state_q;
    next_key_d  = next_key_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    lim_d       = lim_q;
    pend_v_d    = pend_v_q;
    pend_key_d  = pend_key_q;
    res_valid_d = 1'b0;
    status_d    = ST_OK;
    out_key_d   = '0;
    hit_d       = 1'b0;
    hit_count_d = '0;
    last_d      = 1'b1;
    do_add = 1'b0; do_del = 1'b0; do_move = 1'b0; do_resize = 1'b0;
    do_clear = 1'b0; do_qstart = 1'b0; do_pick = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (op_i)
            OP_ADD: begin
              if (|free_1h) begin
                do_add     = 1'b1;
                out_key_d  = next_key_q;
                next_key_d = next_key_q + 16'd1;
              end else begin
                status_d = ST_FULL;
              end
            end
            OP_DELETE, OP_MOVE, OP_RESIZE: begin
              if (|match_1h) begin
                do_del    = (op_i == OP_DELETE);
                do_move   = (op_i == OP_MOVE);
                do_resize = (op_i == OP_RESIZE);
              end else begin
                status_d = ST_NOTFOUND;
              end
            end
            OP_CLEAR: begin
              do_clear   = 1'b1;
              next_key_d = '0;
            end
            OP_QUERY: begin
              do_qstart = 1'b1;
              lim_d     = (hit_limit_i > 7'(MAX_HITS)) ? 7'(MAX_HITS) : hit_limit_i;
              if (hit_limit_i != '0) begin
                // No result yet: the first pass decides what comes out.
                res_valid_d = 1'b0;
                state_d     = FSM_SCAN;
                cnt_d       = '0;
                n_d         = '0;
                pend_v_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SCAN: begin
        if (cnt_q != CNTW'(ENTRIES)) begin
          cnt_d = cnt_q + CNTW'(1);
        end else if (chain[ENTRIES].vld) begin
          do_pick     = 1'b1;
          n_d         = n_q + 7'd1;
          pend_v_d    = 1'b1;
          pend_key_d  = chain[ENTRIES].key;
          cnt_d       = '0;
          // The previous hit is known not to be the final one now.
          res_valid_d = pend_v_q;
          out_key_d   = pend_key_q;
          hit_d       = 1'b1;
          hit_count_d = n_q;
          last_d      = 1'b0;
          if (n_q + 7'd1 == lim_q) begin
            state_d = FSM_FLUSH;
          end
        end else begin
          res_valid_d = 1'b1;
          state_d     = FSM_IDLE;
          if (pend_v_q) begin
            out_key_d   = pend_key_q;
            hit_d       = 1'b1;
            hit_count_d = n_q;
          end
        end
      end
      FSM_FLUSH: begin
        res_valid_d = 1'b1;
        out_key_d   = pend_key_q;
        hit_d       = 1'b1;
        hit_count_d = n_q;
        state_d     = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase

    for (int i = 0; i < ENTRIES; i++) begin
      cmd[i].add    = do_add && free_1h[i];
      cmd[i].del    = do_del && match_1h[i];
      cmd[i].move   = do_move && match_1h[i];
      cmd[i].resize = do_resize && match_1h[i];
      cmd[i].clear  = do_clear;
      cmd[i].qstart = do_qstart;
      cmd[i].pick   = do_pick && pick_vec[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      sort_by_y_q <= 1'b0;
      next_key_q  <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      lim_q       <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_key_q  <= next_key_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      lim_q       <= lim_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        sort_by_y_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_key_q  <= pend_key_d;
    status_q    <= status_d;
    out_key_q   <= out_key_d;
    hit_q       <= hit_d;
    hit_count_q <= hit_count_d;
    last_q      <= last_d;
    if (start_i && is_idle) begin
      qx_q  <= pos_x_i;
      qy_q  <= pos_y_i;
      qxb_q <= cell_xb;
      qyb_q <= cell_yb;
    end
  end

  assign busy_o      = !is_idle;
  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign hit_o       = hit_q;
  assign hit_count_o = hit_count_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // An error status always closes its request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != ST_OK) |-> last_o)
    else $error("error result without last");

  // At most one slot is written by a table update.
  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(free_1h) && $onehot0(match_1h))
    else $error("more than one slot selected");

  // Leaving a query always comes with a final result.
  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) != FSM_IDLE && state_q == FSM_IDLE) |-> (res_valid_o && last_o))
    else $error("query ended without final result");

  // Hit counts on a hit result are nonzero and never pass MAX_HITS.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && hit_o) |-> (hit_count_o <= 7'(MAX_HITS) && hit_count_o != '0))
    else $error("hit count out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for aabb_table_overlap_query_unit
// Drives box table requests (add, delete, move, resize, clear, query and the
// unused op codes), predicts every result from its own model of the table,
// and checks each result strobe field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import aotq_pkg::*;

  // The two op codes the block does not define; it answers them with an
  // empty final result.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key;
    logic        hit;
    logic [6:0]  count;
    logic        last;
  } box_res_t;

  // One row of the directed table. When fixed is set, the first (and only)
  // result of the request is the typed one instead of the predicted one.
  typedef struct {
    logic [2:0]  op;
    logic [15:0] key;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [6:0]  lim;
    bit          fixed;
    box_res_t    res;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  op_i = '0;
  logic [15:0] box_key_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] size_w_i = '0;
  logic [15:0] size_h_i = '0;
  logic [6:0]  hit_limit_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        res_valid_o;
  logic [1:0]  status_o;
  logic [15:0] out_key_o;
  logic        hit_o;
  logic [6:0]  hit_count_o;
  logic        last_o;

  aabb_table_overlap_query_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .box_key_i   (box_key_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .size_w_i    (size_w_i),
    .size_h_i    (size_h_i),
    .hit_limit_i (hit_limit_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .hit_o       (hit_o),
    .hit_count_o (hit_count_o),
    .last_o      (last_o)
  );

  // Shadow copy of the box table and its key counter.
  bit          box_vld[ENTRIES];
  logic [15:0] box_key[ENTRIES];
  logic [15:0] box_left[ENTRIES];
  logic [15:0] box_top[ENTRIES];
  logic [15:0] box_wid[ENTRIES];
  logic [15:0] box_hgt[ENTRIES];
  logic [15:0] key_ctr;
  bit          order_by_top;

  box_res_t hits_due[$];    // results still owed by the block, oldest first
  box_res_t req_results[$]; // results of the request being predicted
  int       errors;
  int       sender_idle_pct;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Generous ceiling: a few hundred requests, queries included, with idle gaps
  // stay well under a millisecond.
  initial begin
    #5ms;
    $display("[aabb_table_overlap_query_unit] ERROR");
    $finish;
  end

  function automatic box_res_t mk_res(logic [1:0] st, logic [15:0] k, logic hv,
                                      logic [6:0] c, logic l);
    box_res_t r;
    r.status = st;
    r.key    = k;
    r.hit    = hv;
    r.count  = c;
    r.last   = l;
    return r;
  endfunction

  // True when slot a is reported ahead of slot b.
  function automatic bit ranks_ahead(int a, int b);
    logic [15:0] ea;
    logic [15:0] eb;
    ea = order_by_top ? box_top[a] : box_left[a];
    eb = order_by_top ? box_top[b] : box_left[b];
    if (ea != eb) return ea < eb;
    if (box_key[a] != box_key[b]) return box_key[a] < box_key[b];
    return a < b;
  endfunction

  // Updates the shadow table for one request and fills req_results.
  task automatic predict_table(input logic [2:0] op, input logic [15:0] k,
                               input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic [6:0] lim);
    int          slot;
    int          best;
    int          n;
    int          cap;
    bit          hitset[ENTRIES];
    bit          taken[ENTRIES];
    logic [16:0] qx_far;
    logic [16:0] qy_far;
    logic [16:0] ex_far;
    logic [16:0] ey_far;
    req_results.delete();
    slot = -1;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !box_vld[i]) slot = i;
        if (slot < 0) begin
          req_results.push_back(mk_res(ST_FULL, '0, 1'b0, '0, 1'b1));
        end else begin
          box_vld[slot]  = 1'b1;
          box_key[slot]  = key_ctr;
          box_left[slot] = x;
          box_top[slot]  = y;
          box_wid[slot]  = w;
          box_hgt[slot]  = h;
          req_results.push_back(mk_res(ST_OK, key_ctr, 1'b0, '0, 1'b1));
          key_ctr = key_ctr + 16'd1;
        end
      end
      OP_DELETE, OP_MOVE, OP_RESIZE: begin
        // Duplicate keys resolve to the lowest matching slot.
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && box_vld[i] && box_key[i] == k) slot = i;
        if (slot < 0) begin
          req_results.push_back(mk_res(ST_NOTFOUND, '0, 1'b0, '0, 1'b1));
        end else begin
          if (op == OP_DELETE) begin
            box_vld[slot] = 1'b0;
          end else if (op == OP_MOVE) begin
            box_left[slot] = x;
            box_top[slot]  = y;
          end else begin
            box_wid[slot] = w;
            box_hgt[slot] = h;
          end
          req_results.push_back(mk_res(ST_OK, '0, 1'b0, '0, 1'b1));
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) box_vld[i] = 1'b0;
        key_ctr = '0;
        req_results.push_back(mk_res(ST_OK, '0, 1'b0, '0, 1'b1));
      end
      OP_QUERY: begin
        // Far edges are 17-bit sums, so nothing wraps.
        qx_far = {1'b0, x} + {1'b0, w};
        qy_far = {1'b0, y} + {1'b0, h};
        cap = (lim > MAX_HITS) ? MAX_HITS : lim;
        for (int i = 0; i < ENTRIES; i++) begin
          ex_far = {1'b0, box_left[i]} + {1'b0, box_wid[i]};
          ey_far = {1'b0, box_top[i]} + {1'b0, box_hgt[i]};
          hitset[i] = box_vld[i] && ex_far > {1'b0, x} && {1'b0, box_left[i]} < qx_far
                      && ey_far > {1'b0, y} && {1'b0, box_top[i]} < qy_far;
          taken[i] = 1'b0;
        end
        n = 0;
        best = 0;
        while (n < cap && best >= 0) begin
          best = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (hitset[i] && !taken[i] && (best < 0 || ranks_ahead(i, best))) best = i;
          if (best >= 0) begin
            taken[best] = 1'b1;
            n++;
            req_results.push_back(mk_res(ST_OK, box_key[best], 1'b1, n[6:0], 1'b0));
          end
        end
        if (n == 0) req_results.push_back(mk_res(ST_OK, '0, 1'b0, '0, 1'b1));
        else req_results[n-1].last = 1'b1;
      end
      default: begin
        req_results.push_back(mk_res(ST_OK, '0, 1'b0, '0, 1'b1));
      end
    endcase
  endtask

  // Presents one request from a falling edge; busy_o only moves at rising
  // edges, so a low busy_o seen here means the request is taken at the next
  // rising edge. Returns at the falling edge after acceptance, with start_i
  // still high unless the sender then idles, so back-to-back requests leave no gap.
  task automatic send_req(input logic [2:0] op, input logic [15:0] k,
                          input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [6:0] lim, input bit fixed,
                          input box_res_t fixed_res);
    if (busy_o) begin
      start_i = 1'b0;
      while (busy_o) @(negedge clk_i);
    end
    op_i        = op;
    box_key_i   = k;
    pos_x_i     = x;
    pos_y_i     = y;
    size_w_i    = w;
    size_h_i    = h;
    hit_limit_i = lim;
    start_i     = 1'b1;
    predict_table(op, k, x, y, w, h, lim);
    if (fixed) hits_due.push_back(fixed_res);
    else foreach (req_results[i]) hits_due.push_back(req_results[i]);
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed result has come back, then keeps
  // waiting so that the block is surely idle.
  task automatic drain;
    start_i = 1'b0;
    while (hits_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_order(input bit by_top);
    cfg_wdata_i = by_top;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    order_by_top = by_top;
  endtask

  // Edge or size: mostly a small range so that boxes overlap, sometimes the
  // full range or the top value.
  function automatic logic [15:0] rand_span(int hi);
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 16'($urandom_range(hi));
    if (sel < 9) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  // Mostly a key that lives in the table, otherwise any key.
  function automatic logic [15:0] pick_key;
    int live[$];
    for (int i = 0; i < ENTRIES; i++)
      if (box_vld[i]) live.push_back(i);
    if (live.size() != 0 && $urandom_range(9) < 8)
      return box_key[live[$urandom_range(live.size() - 1)]];
    return 16'($urandom);
  endfunction

  task automatic random_reqs(input int count);
    int          sel;
    logic [2:0]  op;
    logic [6:0]  lim;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 32) op = OP_ADD;
      else if (sel < 44) op = OP_DELETE;
      else if (sel < 53) op = OP_MOVE;
      else if (sel < 62) op = OP_RESIZE;
      else if (sel < 65) op = OP_CLEAR;
      else if (sel < 96) op = OP_QUERY;
      else op = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      sel = $urandom_range(9);
      if (sel < 6) lim = 7'd64;
      else if (sel < 8) lim = 7'($urandom_range(1, 20));
      else lim = 7'($urandom);
      send_req(op, pick_key(), rand_span(400), rand_span(400), rand_span(150),
               rand_span(150), lim, 1'b0, '0);
    end
  endtask

  // Results are sampled at the rising edge that ends the strobe cycle.
  always @(posedge clk_i) begin
    box_res_t got;
    box_res_t want;
    if (rst_ni && res_valid_o) begin
      got = mk_res(status_o, out_key_o, hit_o, hit_count_o, last_o);
      if (hits_due.size() == 0) begin
        errors++;
        $display("%t result with nothing owed: status=%0d key=%h hit=%b count=%0d last=%b",
                 $realtime, got.status, got.key, got.hit, got.count, got.last);
      end else begin
        want = hits_due.pop_front();
        if (got.status !== want.status || got.key !== want.key || got.hit !== want.hit
            || got.count !== want.count || got.last !== want.last) begin
          errors++;
          $display("%t mismatch: expected status=%0d key=%h hit=%b count=%0d last=%b",
                   $realtime, want.status, want.key, want.hit, want.count, want.last);
          $display("%t           actual   status=%0d key=%h hit=%b count=%0d last=%b",
                   $realtime, got.status, got.key, got.hit, got.count, got.last);
        end
      end
    end
  end

  req_row_t rows[$];

  initial begin
    errors = 0;
    sender_idle_pct = 0;
    key_ctr = '0;
    order_by_top = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      box_vld[i] = 1'b0;
      box_key[i] = '0;
      box_left[i] = '0;
      box_top[i] = '0;
      box_wid[i] = '0;
      box_hgt[i] = '0;
    end

    // Directed requests. Typed results are the ones plain from the spec:
    // empty table, first keys, error codes, the unused ops and a zero limit.
    rows = '{
      '{OP_QUERY,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd64, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_DELETE,   16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b1,
        mk_res(ST_NOTFOUND, '0, 1'b0, '0, 1'b1)},
      '{OP_ADD,      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b1,
        mk_res(ST_OK, 16'd0, 1'b0, '0, 1'b1)},
      '{OP_ADD,      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b1,
        mk_res(ST_OK, 16'd1, 1'b0, '0, 1'b1)},
      '{OP_ADD,      16'h0000, 16'd100, 16'd100, 16'd50, 16'd50, 7'd0, 1'b1,
        mk_res(ST_OK, 16'd2, 1'b0, '0, 1'b1)},
      '{OP_ADD,      16'h0000, 16'd100, 16'd20, 16'd10, 16'd200, 7'd0, 1'b1,
        mk_res(ST_OK, 16'd3, 1'b0, '0, 1'b1)},
      '{OP_QUERY,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd64, 1'b0, '0},
      '{OP_QUERY,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_QUERY,    16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b0, '0},
      '{OP_QUERY,    16'h0000, 16'd110, 16'd110, 16'd1, 16'd1, 7'd1, 1'b0, '0},
      '{OP_QUERY,    16'h0000, 16'd150, 16'd0, 16'd5, 16'd500, 7'd64, 1'b0, '0},
      '{OP_MOVE,     16'h0002, 16'd99, 16'd5, 16'd0, 16'd0, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_RESIZE,   16'h0001, 16'd0, 16'd0, 16'd300, 16'd300, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_MOVE,     16'h1234, 16'd1, 16'd1, 16'd0, 16'd0, 7'd0, 1'b1,
        mk_res(ST_NOTFOUND, '0, 1'b0, '0, 1'b1)},
      '{OP_RESIZE,   16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd1, 7'd0, 1'b1,
        mk_res(ST_NOTFOUND, '0, 1'b0, '0, 1'b1)},
      '{OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_SPARE_HI, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_QUERY,    16'h0000, 16'd0, 16'd0, 16'd400, 16'd400, 7'd64, 1'b0, '0},
      '{OP_DELETE,   16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_QUERY,    16'h0000, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'd64, 1'b0, '0},
      '{OP_CLEAR,    16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 1'b1,
        mk_res(ST_OK, '0, 1'b0, '0, 1'b1)},
      '{OP_ADD,      16'h0000, 16'd7, 16'd7, 16'd7, 16'd7, 7'd0, 1'b1,
        mk_res(ST_OK, 16'd0, 1'b0, '0, 1'b1)}
    };

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_req(rows[i].op, rows[i].key, rows[i].x, rows[i].y, rows[i].w, rows[i].h,
               rows[i].lim, rows[i].fixed, rows[i].res);

    // Fill the table to the last slot, then one add past it reports full.
    for (int i = 1; i < ENTRIES; i++)
      send_req(OP_ADD, '0, rand_span(300), rand_span(300), rand_span(100),
               rand_span(100), '0, 1'b0, '0);
    send_req(OP_ADD, '0, 16'd1, 16'd1, 16'd1, 16'd1, '0, 1'b1,
             mk_res(ST_FULL, '0, 1'b0, '0, 1'b1));
    send_req(OP_QUERY, '0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'd64, 1'b0, '0);

    // Hold off until the block has answered everything.
    drain();
    write_order(1'b1);
    send_req(OP_QUERY, '0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'd64, 1'b0, '0);

    // Two boxes with the same edges, so their order falls to the key, and a
    // third one that sorts differently by left and by top edge.
    send_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, '0);
    send_req(OP_ADD, '0, 16'd10, 16'd10, 16'd20, 16'd20, '0, 1'b0, '0);
    send_req(OP_ADD, '0, 16'd10, 16'd10, 16'd20, 16'd20, '0, 1'b0, '0);
    send_req(OP_ADD, '0, 16'd5, 16'd40, 16'd20, 16'd20, '0, 1'b0, '0);
    send_req(OP_QUERY, '0, 16'd0, 16'd0, 16'd100, 16'd100, 7'd64, 1'b0, '0);
    send_req(OP_MOVE, 16'd0, 16'd12, 16'd2, '0, '0, '0, 1'b0, '0);
    send_req(OP_QUERY, '0, 16'd0, 16'd0, 16'd100, 16'd100, 7'd64, 1'b0, '0);
    send_req(OP_DELETE, 16'd0, '0, '0, '0, '0, '0, 1'b0, '0);
    send_req(OP_QUERY, '0, 16'd0, 16'd0, 16'd100, 16'd100, 7'd64, 1'b0, '0);
    send_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0, '0);

    // Random phases with different sender idling and sort order.
    drain();
    write_order(1'b0);
    sender_idle_pct = 0;
    random_reqs(50);
    drain();
    write_order(1'b1);
    sender_idle_pct = 76;
    random_reqs(50);
    drain();
    write_order(1'b0);
    sender_idle_pct = 0;
    random_reqs(45);
    drain();
    write_order(1'b1);
    sender_idle_pct = 8;
    random_reqs(45);

    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("[aabb_table_overlap_query_unit] OK");
    end else begin
      $display("[aabb_table_overlap_query_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aotq_pkg.sv
rtl/aotq_cell.sv
rtl/aabb_table_overlap_query_unit.sv
tb/testbench.sv
